@@ hw/rtl/sala_pkg.sv @@
// shared constants, types and helpers for the skyline atlas allocator
`timescale 1ns / 1ps
`default_nettype none

package sala_pkg;

	// page geometry and page budget
	localparam int COLUMNS   = 128;
	localparam int ROWS      = 128;
	localparam int MAX_PAGES = 128;

	// widths
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int FILL_W = $clog2(ROWS + 1);
	localparam int SIZE_W = 8;
	localparam int POS_W  = 7;
	localparam int PAGE_W = 8;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;
	localparam int SUM_W  = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RESET  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_PLACED    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NEW_PAGE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_PAGES  = 2'd3;

	// commands to the skyline engine
	typedef enum logic [1:0] {
		ENG_SCAN,
		ENG_ORIGIN,
		ENG_CLEAR
	} eng_op_t;

	typedef struct packed {
		logic              start;
		eng_op_t           op;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} eng_cmd_t;

	typedef struct packed {
		logic              done;
		logic              fit;
		logic [COL_W-1:0]  x;
		logic [FILL_W-1:0] y;
	} eng_rsp_t;

	// keep the low position bits of a zero-extended coordinate
	function automatic logic [POS_W-1:0] pos_mask(input logic [15:0] v);
		return v[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sala_if.sv @@
// request and response channel interfaces of the skyline atlas allocator
`timescale 1ns / 1ps
`default_nettype none

interface sala_req_if import sala_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [SIZE_W-1:0] rect_width;
	logic [SIZE_W-1:0] rect_height;

	modport source(output valid, action, rect_width, rect_height, input ready);
	modport sink(input valid, action, rect_width, rect_height, output ready);
endinterface

interface sala_rsp_if import sala_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [PAGE_W-1:0] page;
	logic [STAT_W-1:0] status;

	modport source(output valid, pos_x, pos_y, page, status, input ready);
	modport sink(input valid, pos_x, pos_y, page, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sala_skyline.sv @@
// skyline engine: column memories, window maximum scan and column update
`timescale 1ns / 1ps
`default_nettype none

module sala_skyline import sala_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire eng_cmd_t cmd,
	output eng_rsp_t      eng
);

	typedef enum logic [2:0] {
		E_IDLE,
		E_BACK,
		E_FWD,
		E_FIT,
		E_UPD
	} eng_state_t;

	eng_state_t state_q;

	// column fill memory with per-column valid bits, block suffix maximum memory
	logic [FILL_W-1:0] fill_mem [COLUMNS];
	logic [FILL_W-1:0] suf_mem  [COLUMNS];
	logic [COLUMNS-1:0] fill_vld_q;

	logic [SIZE_W-1:0] h_q;
	logic [COL_W-1:0]  wm1_q;
	logic              w_ok_q;
	logic [COL_W-1:0]  iss_q;
	logic              iss_on_q;
	logic [COL_W-1:0]  pc_q;
	logic [FILL_W-1:0] run_q;
	logic [FILL_W-1:0] best_q;
	logic [COL_W-1:0]  bx_q;
	logic [COL_W-1:0]  k_q;
	logic [FILL_W-1:0] new_q;
	logic              done_q;
	logic              fit_q;

	// read stage
	logic              v_s1;
	logic              last_s1;
	logic              win_s1;
	logic [COL_W-1:0]  idx_s1;
	logic [FILL_W-1:0] fill_s1;
	logic              vld_s1;
	logic [FILL_W-1:0] suf_s1;

	logic [FILL_W-1:0] f_val;
	logic [FILL_W-1:0] f_run_max;
	logic [FILL_W-1:0] back_val;
	logic [FILL_W-1:0] pre_val;
	logic [FILL_W-1:0] win_max;
	logic [SUM_W-1:0]  sum;
	logic              fits;
	logic [COL_W-1:0]  suf_raddr;
	logic [COL_W-1:0]  upd_addr;
	logic              clr;
	logic              upd_we;
	logic              suf_we;
	logic              w_big;

	// shared max and compare logic of the scan passes
	always_comb begin
		f_val     = vld_s1 ? fill_s1 : '0;
		f_run_max = (f_val > run_q) ? f_val : run_q;
		back_val  = (pc_q == '0) ? f_val : f_run_max;
		pre_val   = ((pc_q == wm1_q) || (idx_s1 == '0)) ? f_val : f_run_max;
		win_max   = (suf_s1 > pre_val) ? suf_s1 : pre_val;
		sum       = SUM_W'(best_q) + SUM_W'(h_q);
		fits      = (sum <= SUM_W'(ROWS)) && w_ok_q;
		suf_raddr = iss_q - wm1_q;
		upd_addr  = bx_q + k_q;
		clr       = (state_q == E_IDLE) && cmd.start && (cmd.op != ENG_SCAN);
		upd_we    = (state_q == E_UPD);
		suf_we    = (state_q == E_BACK) && v_s1;
		w_big     = 16'(cmd.w) > 16'(COLUMNS);
	end

	// memory ports
	always_ff @(posedge clk) begin
		fill_s1 <= fill_mem[iss_q];
		suf_s1  <= suf_mem[suf_raddr];
		if (upd_we) begin
			fill_mem[upd_addr] <= new_q;
		end
		if (suf_we) begin
			suf_mem[idx_s1] <= back_val;
		end
	end

	// valid bits: an invalid column reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= fill_vld_q[iss_q];
			if (clr) begin
				fill_vld_q <= '0;
			end else if (upd_we) begin
				fill_vld_q[upd_addr] <= 1'b1;
			end
		end
	end

	// sequencer: backward suffix pass, forward window pass, fit check, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			h_q      <= '0;
			wm1_q    <= '0;
			w_ok_q   <= 1'b0;
			iss_q    <= '0;
			iss_on_q <= 1'b0;
			pc_q     <= '0;
			run_q    <= '0;
			best_q   <= '0;
			bx_q     <= '0;
			k_q      <= '0;
			new_q    <= '0;
			done_q   <= 1'b0;
			fit_q    <= 1'b0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			win_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			done_q  <= 1'b0;
			v_s1    <= iss_on_q;
			idx_s1  <= iss_q;
			win_s1  <= iss_q >= wm1_q;
			last_s1 <= (state_q == E_BACK) ? (iss_q == '0) : (iss_q == COL_W'(COLUMNS - 1));
			unique case (state_q)
				E_IDLE: begin
					if (cmd.start) begin
						h_q    <= cmd.h;
						wm1_q  <= COL_W'(16'(cmd.w) - 16'd1);
						w_ok_q <= !w_big;
						bx_q   <= '0;
						best_q <= FILL_W'(ROWS);
						unique case (cmd.op)
							ENG_SCAN: begin
								if (w_big) begin
									state_q <= E_FIT;
								end else begin
									state_q  <= E_BACK;
									iss_q    <= COL_W'(COLUMNS - 1);
									iss_on_q <= 1'b1;
									pc_q     <= '0;
								end
							end
							ENG_ORIGIN: begin
								best_q  <= '0;
								state_q <= E_FIT;
							end
							default: begin
								done_q <= 1'b1;
								fit_q  <= 1'b0;
							end
						endcase
					end
				end
				E_BACK: begin
					if (iss_on_q) begin
						iss_q <= iss_q - COL_W'(1);
						if (iss_q == '0) begin
							iss_on_q <= 1'b0;
						end
					end
					if (v_s1) begin
						run_q <= back_val;
						if (last_s1) begin
							// pc_q keeps the block phase of column zero
							state_q  <= E_FWD;
							iss_q    <= '0;
							iss_on_q <= 1'b1;
						end else begin
							pc_q <= (pc_q == wm1_q) ? '0 : pc_q + COL_W'(1);
						end
					end
				end
				E_FWD: begin
					if (iss_on_q) begin
						iss_q <= iss_q + COL_W'(1);
						if (iss_q == COL_W'(COLUMNS - 1)) begin
							iss_on_q <= 1'b0;
						end
					end
					if (v_s1) begin
						run_q <= pre_val;
						pc_q  <= (pc_q == '0) ? wm1_q : pc_q - COL_W'(1);
						if (win_s1 && (win_max < best_q)) begin
							best_q <= win_max;
							bx_q   <= idx_s1 - wm1_q;
						end
						if (last_s1) begin
							state_q <= E_FIT;
						end
					end
				end
				E_FIT: begin
					if (fits) begin
						state_q <= E_UPD;
						k_q     <= '0;
						new_q   <= FILL_W'(sum);
					end else begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
						fit_q   <= 1'b0;
					end
				end
				E_UPD: begin
					k_q <= k_q + COL_W'(1);
					if (k_q == wm1_q) begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
						fit_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign eng.done = done_q;
	assign eng.fit  = fit_q;
	assign eng.x    = bx_q;
	assign eng.y    = best_q;

	// best height never rises above the page
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= FILL_W'(ROWS))
		else $error("best height above page");

	// column update stays inside the page
	a_upd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_UPD) |-> (({1'b0, bx_q} + {1'b0, k_q}) < (COL_W + 1)'(COLUMNS)))
		else $error("column update outside page");

	// a finished update leaves the last covered column valid
	a_upd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && fit_q) |-> fill_vld_q[bx_q + wm1_q])
		else $error("placed rectangle left columns empty");

endmodule

`default_nettype wire

@@ hw/rtl/skyline_atlas_allocator_unit.sv @@
// top level: action decode, page counting, retry on a new page, result register
// allocate: two scan passes (one column a cycle), a fit check and, if placed, a column update;
// a retry on a new page redoes fit check and update at the origin; reset and finish clear the
// skyline; zero sizes, the unused action and a finish past the budget go straight to the result
// one item is in work at a time; the next is taken the cycle after its result is registered
// arst_n clears the page count, the column valid bits and all control state at once
`timescale 1ns / 1ps
`default_nettype none

module skyline_atlas_allocator_unit import sala_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sala_req_if.sink    req,
	sala_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_WAIT1,
		T_WAIT2,
		T_HOLD
	} top_state_t;

	top_state_t state_q;

	logic [ACT_W-1:0]  act_q;
	logic [SIZE_W-1:0] w_q;
	logic [SIZE_W-1:0] h_q;
	logic [PAGE_W-1:0] page_q;
	logic [POS_W-1:0]  res_x_q;
	logic [POS_W-1:0]  res_y_q;
	logic [STAT_W-1:0] res_st_q;
	logic              out_vld_q;
	logic [POS_W-1:0]  out_x_q;
	logic [POS_W-1:0]  out_y_q;
	logic [PAGE_W-1:0] out_page_q;
	logic [STAT_W-1:0] out_st_q;
	eng_cmd_t          cmd_q;
	eng_rsp_t          eng;
	logic              pages_full;

	sala_skyline u_skyline (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.eng    (eng)
	);

	assign pages_full = page_q >= PAGE_W'(MAX_PAGES);
	assign req.ready  = (state_q == T_IDLE);
	assign rsp.valid  = out_vld_q;
	assign rsp.pos_x  = out_x_q;
	assign rsp.pos_y  = out_y_q;
	assign rsp.page   = out_page_q;
	assign rsp.status = out_st_q;

	// item sequencing and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			act_q      <= '0;
			w_q        <= '0;
			h_q        <= '0;
			page_q     <= '0;
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_st_q   <= ST_PLACED;
			out_vld_q  <= 1'b0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_page_q <= '0;
			out_st_q   <= ST_PLACED;
			cmd_q      <= '0;
		end else begin
			cmd_q.start <= 1'b0;
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (req.valid) begin
						act_q    <= req.action;
						w_q      <= req.rect_width;
						h_q      <= req.rect_height;
						res_x_q  <= '0;
						res_y_q  <= '0;
						res_st_q <= ST_PLACED;
						cmd_q.w  <= req.rect_width;
						cmd_q.h  <= req.rect_height;
						unique case (req.action)
							ACT_ALLOC: begin
								if ((req.rect_width == '0) || (req.rect_height == '0)) begin
									res_st_q <= ST_TOO_LARGE;
									state_q  <= T_HOLD;
								end else begin
									cmd_q.start <= 1'b1;
									cmd_q.op    <= ENG_SCAN;
									state_q     <= T_WAIT1;
								end
							end
							ACT_RESET: begin
								page_q      <= '0;
								cmd_q.start <= 1'b1;
								cmd_q.op    <= ENG_CLEAR;
								state_q     <= T_WAIT1;
							end
							ACT_FINISH: begin
								if (pages_full) begin
									res_st_q <= ST_NO_PAGES;
									state_q  <= T_HOLD;
								end else begin
									page_q      <= page_q + PAGE_W'(1);
									cmd_q.start <= 1'b1;
									cmd_q.op    <= ENG_CLEAR;
									state_q     <= T_WAIT1;
								end
							end
							default: begin
								state_q <= T_HOLD;
							end
						endcase
					end
				end
				T_WAIT1: begin
					if (eng.done) begin
						if (act_q != ACT_ALLOC) begin
							state_q <= T_HOLD;
						end else if (eng.fit) begin
							res_x_q  <= pos_mask(16'(eng.x));
							res_y_q  <= pos_mask(16'(eng.y));
							res_st_q <= ST_PLACED;
							state_q  <= T_HOLD;
						end else if (pages_full) begin
							res_st_q <= ST_NO_PAGES;
							state_q  <= T_HOLD;
						end else begin
							// close the page and retry on an empty skyline
							page_q      <= page_q + PAGE_W'(1);
							cmd_q.start <= 1'b1;
							cmd_q.op    <= ENG_ORIGIN;
							cmd_q.w     <= w_q;
							cmd_q.h     <= h_q;
							state_q     <= T_WAIT2;
						end
					end
				end
				T_WAIT2: begin
					if (eng.done) begin
						if (eng.fit) begin
							res_x_q  <= pos_mask(16'(eng.x));
							res_y_q  <= pos_mask(16'(eng.y));
							res_st_q <= ST_NEW_PAGE;
						end else begin
							res_st_q <= ST_TOO_LARGE;
						end
						state_q <= T_HOLD;
					end
				end
				T_HOLD: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_x_q    <= res_x_q;
						out_y_q    <= res_y_q;
						out_page_q <= page_q;
						out_st_q   <= res_st_q;
						state_q    <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// the engine only reports while an item waits on it
	a_eng_done: assert property (@(posedge clk) disable iff (!arst_n)
		eng.done |-> ((state_q == T_WAIT1) || (state_q == T_WAIT2)))
		else $error("engine done with no item waiting");

	// page count never passes the budget
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		page_q <= PAGE_W'(MAX_PAGES))
		else $error("page count above budget");

	// a new-page placement always follows a page close
	a_new_page: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_st_q == ST_NEW_PAGE)) |-> (out_page_q != '0))
		else $error("new page reported with no closed page");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the skyline atlas allocator: queued driver, checking monitor
`timescale 1ns / 1ps

module testbench;
	import sala_pkg::*;

	// unused action code, expected to be a no-op
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	localparam int RANDOM_ITEMS  = 380;
	localparam int PRESSURE_HOLD = 3000;
	localparam int TAIL_CYCLES   = 1200;
	localparam int CYCLE_LIMIT   = 5000000;
	localparam int PRINT_CAP     = 100;

	typedef struct {
		logic [ACT_W-1:0]  action;
		logic [SIZE_W-1:0] rect_width;
		logic [SIZE_W-1:0] rect_height;
	} request_t;

	typedef struct {
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [PAGE_W-1:0] page;
		logic [STAT_W-1:0] status;
	} placement_t;

	logic clk;
	logic arst_n;

	sala_req_if req();
	sala_rsp_if rsp();

	skyline_atlas_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// requests waiting to be offered, placements waiting to come back
	request_t    pending_q[$];
	placement_t  placements_q[$];

	// own copy of the page state
	int unsigned skyline [COLUMNS];
	int unsigned pages_closed;

	int          mismatches;
	int          cycle_count;
	int          send_idle;
	int          recv_stall;
	int          hold_left;
	int          results_taken;
	bit          pressure_done;
	bit          send_calm;
	bit          recv_calm;
	placement_t  want;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("cycle %0d: %s", cycle_count, msg);
		end
		mismatches++;
	endtask

	function automatic void clear_skyline();
		foreach (skyline[c]) skyline[c] = 0;
	endfunction

	// bottom-left search: leftmost start whose tallest covered column is lowest
	function automatic bit place_on_page(input int unsigned w, input int unsigned h,
			output int unsigned px, output int unsigned py);
		int unsigned lowest;
		int unsigned left;
		int unsigned top;
		px = 0;
		py = 0;
		lowest = ROWS;
		left = 0;
		for (int unsigned s = 0; s + w <= COLUMNS; s++) begin
			top = 0;
			for (int unsigned k = 0; k < w; k++) begin
				if (skyline[s + k] > top) top = skyline[s + k];
			end
			if (top < lowest) begin
				lowest = top;
				left = s;
			end
		end
		if (lowest + h > ROWS) return 1'b0;
		for (int unsigned k = 0; k < w; k++) skyline[left + k] = lowest + h;
		px = left;
		py = lowest;
		return 1'b1;
	endfunction

	// expected placement for one request, updating the page state
	function automatic placement_t predict_placement(input logic [ACT_W-1:0] act,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		placement_t  r;
		int unsigned px;
		int unsigned py;
		px = 0;
		py = 0;
		r.status = ST_PLACED;
		case (act)
			ACT_RESET: begin
				clear_skyline();
				pages_closed = 0;
			end
			ACT_FINISH: begin
				if (pages_closed >= MAX_PAGES) begin
					r.status = ST_NO_PAGES;
				end else begin
					pages_closed++;
					clear_skyline();
				end
			end
			ACT_ALLOC: begin
				if (w == 0 || h == 0) begin
					r.status = ST_TOO_LARGE;
				end else if (place_on_page(32'(w), 32'(h), px, py)) begin
					r.status = ST_PLACED;
				end else if (pages_closed >= MAX_PAGES) begin
					r.status = ST_NO_PAGES;
				end else begin
					pages_closed++;
					clear_skyline();
					if (place_on_page(32'(w), 32'(h), px, py)) begin
						r.status = ST_NEW_PAGE;
					end else begin
						px = 0;
						py = 0;
						r.status = ST_TOO_LARGE;
					end
				end
			end
			default: begin
			end
		endcase
		r.pos_x = px[POS_W-1:0];
		r.pos_y = py[POS_W-1:0];
		r.page  = pages_closed[PAGE_W-1:0];
		return r;
	endfunction

	// idle length: mostly short, a few long, none while calm
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 10);
		return $urandom_range(20, 400);
	endfunction

	// rectangle side: mostly small, some page sized, rarely oversized or zero
	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) return $urandom_range(1, 16);
		if (r < 91) return $urandom_range(17, 64);
		if (r < 97) return $urandom_range(65, 128);
		if (r < 99) return $urandom_range(129, 255);
		return 0;
	endfunction

	task automatic add_item(input logic [ACT_W-1:0] act, input int w, input int h);
		request_t it;
		it.action      = act;
		it.rect_width  = w[SIZE_W-1:0];
		it.rect_height = h[SIZE_W-1:0];
		pending_q.push_back(it);
	endtask

	// sender: offers queued items with random gaps, predicts on each accepted item
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				placements_q.push_back(predict_placement(req.action, req.rect_width,
					req.rect_height));
			end
			if (!req.valid || req.ready) begin
				if (send_idle > 0) begin
					send_idle--;
					req.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req.action      <= pending_q[0].action;
					req.rect_width  <= pending_q[0].rect_width;
					req.rect_height <= pending_q[0].rect_height;
					req.valid       <= 1'b1;
					void'(pending_q.pop_front());
					if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
					send_idle = pick_gap(send_calm);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) results_taken++;
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!pressure_done && results_taken >= 30) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_HOLD;
				rsp.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ((rsp.valid && rsp.ready) || $urandom_range(0, 15) == 0) begin
					if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
					recv_stall = pick_gap(recv_calm);
				end
			end
		end
	end

	// monitor: compare each accepted result with the oldest placement
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (placements_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result x=%0d y=%0d page=%0d status=%0d",
					rsp.pos_x, rsp.pos_y, rsp.page, rsp.status));
			end else begin
				want = placements_q.pop_front();
				if (rsp.pos_x !== want.pos_x)
					report_mismatch($sformatf("pos_x %0d, expected %0d", rsp.pos_x, want.pos_x));
				if (rsp.pos_y !== want.pos_y)
					report_mismatch($sformatf("pos_y %0d, expected %0d", rsp.pos_y, want.pos_y));
				if (rsp.page !== want.page)
					report_mismatch($sformatf("page %0d, expected %0d", rsp.page, want.page));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", rsp.status,
						want.status));
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int pick;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.action      = ACT_ALLOC;
		req.rect_width  = '0;
		req.rect_height = '0;
		rsp.ready       = 1'b0;
		mismatches      = 0;
		cycle_count     = 0;
		send_idle       = 0;
		recv_stall      = 0;
		hold_left       = 0;
		results_taken   = 0;
		pressure_done   = 1'b0;
		send_calm       = 1'b0;
		recv_calm       = 1'b0;
		pages_closed    = 0;
		clear_skyline();

		// directed: extremes, every action, zero and oversized sizes
		add_item(ACT_RESET, 0, 0);
		add_item(ACT_ALLOC, 1, 1);
		add_item(ACT_ALLOC, 128, 128);
		add_item(ACT_ALLOC, 128, 1);
		add_item(ACT_ALLOC, 129, 1);
		add_item(ACT_ALLOC, 1, 129);
		add_item(ACT_ALLOC, 0, 5);
		add_item(ACT_ALLOC, 5, 0);
		add_item(ACT_ALLOC, 255, 255);
		add_item(ACT_NONE, 'hAA, 'h55);
		add_item(ACT_FINISH, 'h55, 'hAA);
		add_item(ACT_FINISH, 255, 255);
		add_item(ACT_ALLOC, 64, 10);
		add_item(ACT_ALLOC, 64, 20);
		add_item(ACT_ALLOC, 1, 5);
		add_item(ACT_ALLOC, 127, 1);
		add_item(ACT_ALLOC, 128, 1);
		add_item(ACT_RESET, 255, 255);
		add_item(ACT_ALLOC, 1, 128);
		add_item(ACT_ALLOC, 1, 1);
		add_item(ACT_ALLOC, 127, 127);

		// random packing with finishes, resets, no-ops and malformed sizes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// run the page budget out: retry onto the last page, then refusals
				add_item(ACT_RESET, 0, 0);
				for (int f = 0; f < MAX_PAGES - 1; f++) add_item(ACT_FINISH, 0, 0);
				add_item(ACT_ALLOC, 128, 128);
				add_item(ACT_ALLOC, 4, 4);
				add_item(ACT_FINISH, 0, 0);
				add_item(ACT_FINISH, 0, 0);
				add_item(ACT_ALLOC, 128, 124);
				add_item(ACT_ALLOC, 2, 2);
				add_item(ACT_ALLOC, 200, 1);
				add_item(ACT_ALLOC, 0, 0);
				add_item(ACT_NONE, 0, 0);
				add_item(ACT_RESET, 0, 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 84)
				add_item(ACT_ALLOC, pick_side(), pick_side());
			else if (pick < 90)
				add_item(ACT_FINISH, $urandom_range(0, 255), $urandom_range(0, 255));
			else if (pick < 92)
				add_item(ACT_RESET, $urandom_range(0, 255), $urandom_range(0, 255));
			else if (pick < 95)
				add_item(ACT_NONE, $urandom_range(0, 255), $urandom_range(0, 255));
			else
				add_item(ACT_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0 || req.valid || placements_q.size() > 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
